### rtl/sttok_pkg.sv
// ============================================================================
// sttok_pkg
// Shared types and constants for the source text tokenizer: token kinds,
// scanner modes, character codes, the per-byte class record and the keyword
// table.
// ============================================================================
package sttok_pkg;

    localparam int CHAR_W = 8;
    localparam int KIND_W = 5;
    localparam int NUM_W  = 32;
    localparam int LINE_W = 24;
    localparam int MODE_W = 4;

    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

    // Token kinds
    localparam logic [KIND_W-1:0] K_EOF      = 5'd0;
    localparam logic [KIND_W-1:0] K_NEWLINE  = 5'd1;
    localparam logic [KIND_W-1:0] K_ID       = 5'd2;
    localparam logic [KIND_W-1:0] K_STRING   = 5'd3;
    localparam logic [KIND_W-1:0] K_NUMBER   = 5'd4;
    localparam logic [KIND_W-1:0] K_DEFINE   = 5'd5;
    localparam logic [KIND_W-1:0] K_EQUALS   = 5'd6;
    localparam logic [KIND_W-1:0] K_IS       = 5'd7;
    localparam logic [KIND_W-1:0] K_GTE      = 5'd8;
    localparam logic [KIND_W-1:0] K_LTE      = 5'd9;
    localparam logic [KIND_W-1:0] K_KEYWORD0 = 5'd10;
    localparam logic [KIND_W-1:0] K_PUNCT    = 5'd18;
    localparam logic [KIND_W-1:0] K_ERROR    = 5'd19;
    localparam logic [KIND_W-1:0] K_TEXT     = 5'd20;

    // Scanner modes
    localparam logic [MODE_W-1:0] M_IDLE    = 4'd0;
    localparam logic [MODE_W-1:0] M_WORD    = 4'd1;
    localparam logic [MODE_W-1:0] M_NUMBER  = 4'd2;
    localparam logic [MODE_W-1:0] M_STRING  = 4'd3;
    localparam logic [MODE_W-1:0] M_EQ1     = 4'd4;
    localparam logic [MODE_W-1:0] M_EQ2     = 4'd5;
    localparam logic [MODE_W-1:0] M_LT      = 4'd6;
    localparam logic [MODE_W-1:0] M_GT      = 4'd7;
    localparam logic [MODE_W-1:0] M_COLON   = 4'd8;
    localparam logic [MODE_W-1:0] M_SLASH   = 4'd9;
    localparam logic [MODE_W-1:0] M_COMMENT = 4'd10;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_PCT    = 8'h25;
    localparam logic [CHAR_W-1:0] CH_LPAR   = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAR   = 8'h29;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

    // Class record of one source byte, built by the front end. The f_ fields
    // give the outcome of scanning the byte from the idle mode.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              is_alpha;
        logic              is_digit;
        logic [MODE_W-1:0] f_mode;
        logic              f_emit;
        logic [KIND_W-1:0] f_kind;
        logic [CHAR_W-1:0] f_char;
    } t_char_info;

    // Keyword text, first character in the low byte, zero padded.
    function automatic logic [CHAR_W-1:0] kw_char(input logic [2:0] k, input logic [2:0] i);
        logic [63:0] row;
        case (k)
            3'd0:    row = 64'h0000000000006669;  // if
            3'd1:    row = 64'h0000000065736c65;  // else
            3'd2:    row = 64'h00000000636e7566;  // func
            3'd3:    row = 64'h00000000706f6f6c;  // loop
            3'd4:    row = 64'h0000006b61657262;  // break
            3'd5:    row = 64'h65756e69746e6f63;  // continue
            3'd6:    row = 64'h00000065706f6373;  // scope
            default: row = 64'h00000000666c6573;  // self
        endcase
        return row[{i, 3'b000} +: CHAR_W];
    endfunction

    function automatic logic [3:0] kw_len(input logic [2:0] k);
        logic [3:0] len;
        case (k)
            3'd0:    len = 4'd2;
            3'd4:    len = 4'd5;
            3'd5:    len = 4'd8;
            3'd6:    len = 4'd5;
            default: len = 4'd4;
        endcase
        return len;
    endfunction

endpackage

### rtl/sttok_ram.sv
// ============================================================================
// sttok_ram
// Generic single write port, single read port RAM with a registered read.
// ============================================================================
module sttok_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sttok_front.sv
// ============================================================================
// sttok_front
// Input side: classifies each accepted source byte and places its class
// record in a two-entry queue that feeds the scanner.
// ============================================================================
module sttok_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_in_char,
    output logic                  o_stall,
    output logic                  o_q_valid,
    output sttok_pkg::t_char_info o_q_info,
    input  logic                  i_q_pop
);
    import sttok_pkg::*;

    t_char_info info;
    t_char_info r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       push;

    // Character class and the idle-mode scan outcome of the incoming byte.
    always_comb begin
        info          = '0;
        info.ch       = i_in_char;
        info.is_alpha = (i_in_char >= 8'h61 && i_in_char <= 8'h7A) ||
                        (i_in_char >= 8'h41 && i_in_char <= 8'h5A) ||
                        (i_in_char == 8'h5F);
        info.is_digit = (i_in_char >= 8'h30 && i_in_char <= 8'h39);
        info.f_mode   = M_IDLE;
        info.f_emit   = 1'b0;
        info.f_kind   = K_EOF;
        info.f_char   = '0;
        case (i_in_char)
            CH_SPACE, CH_TAB: begin
            end
            CH_NUL: begin
                info.f_emit = 1'b1;
                info.f_kind = K_EOF;
            end
            CH_EQ:     info.f_mode = M_EQ1;
            CH_LT:     info.f_mode = M_LT;
            CH_GT:     info.f_mode = M_GT;
            CH_COLON:  info.f_mode = M_COLON;
            CH_SLASH:  info.f_mode = M_SLASH;
            CH_DQUOTE: info.f_mode = M_STRING;
            CH_LF: begin
                info.f_emit = 1'b1;
                info.f_kind = K_NEWLINE;
            end
            CH_SEMI, CH_LBRACE, CH_RBRACE, CH_COMMA, CH_LPAR, CH_RPAR,
            CH_PLUS, CH_MINUS, CH_STAR, CH_DOT, CH_PCT: begin
                info.f_emit = 1'b1;
                info.f_kind = K_PUNCT;
                info.f_char = i_in_char;
            end
            default: begin
                if (info.is_alpha) begin
                    info.f_mode = M_WORD;
                end else if (info.is_digit) begin
                    info.f_mode = M_NUMBER;
                end else begin
                    info.f_emit = 1'b1;
                    info.f_kind = K_ERROR;
                    info.f_char = i_in_char;
                end
            end
        endcase
    end

    // Queue bookkeeping.
    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_info  = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_q_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_q_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= !r_wr;
            end
            if (i_q_pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= info;
        end
    end

    // The queue never holds more than two beats.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("front queue count out of range");

    // The scanner only takes from a non-empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_cnt != 2'd0)
        else $error("pop from empty front queue");

endmodule

### rtl/sttok_back.sv
// ============================================================================
// sttok_back
// Scanner: takes one classified byte at a time, resolves any pending token,
// scans the byte and sends out the resulting tokens one per cycle, while the
// output is not stalled, through an output register.
// ============================================================================
module sttok_back #(
    parameter int MAX_WORD = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  sttok_pkg::t_char_info       i_q_info,
    output logic                        o_q_pop,
    output logic                        o_ram_we,
    output logic [$clog2(MAX_WORD)-1:0] o_ram_waddr,
    output logic [7:0]                  o_ram_wdata,
    output logic [$clog2(MAX_WORD)-1:0] o_ram_raddr,
    input  logic [7:0]                  i_ram_rdata,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [4:0]                  o_tok_kind,
    output logic [31:0]                 o_num_value,
    output logic [7:0]                  o_char_value,
    output logic [23:0]                 o_line_no,
    output logic                        o_word_truncated,
    output logic                        o_last
);
    import sttok_pkg::*;

    localparam int AW = $clog2(MAX_WORD);
    localparam int CW = $clog2(MAX_WORD + 1);
    localparam logic [CW-1:0] WORD_FULL = CW'(MAX_WORD);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PRE   = 3'd1;
    localparam logic [2:0] ST_FLUSH = 3'd2;
    localparam logic [2:0] ST_ID    = 3'd3;
    localparam logic [2:0] ST_POST  = 3'd4;

    // Control state
    logic [2:0]        r_state, n_state;
    logic [MODE_W-1:0] r_mode, n_mode;
    logic [CW-1:0]     r_wcnt, n_wcnt;
    logic              r_ovf, n_ovf;
    logic [7:0]        r_kw, n_kw;
    logic [NUM_W-1:0]  r_acc, n_acc;
    logic [LINE_W-1:0] r_line, n_line;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_post_valid, n_post_valid;
    logic              r_out_valid;

    // Latched token fields
    logic [KIND_W-1:0] r_pre_kind, n_pre_kind;
    logic [NUM_W-1:0]  r_pre_num, n_pre_num;
    logic [CHAR_W-1:0] r_pre_char, n_pre_char;
    logic [KIND_W-1:0] r_post_kind, n_post_kind;
    logic [CHAR_W-1:0] r_post_char, n_post_char;

    // Output register payload
    logic [KIND_W-1:0] r_out_kind;
    logic [NUM_W-1:0]  r_out_num;
    logic [CHAR_W-1:0] r_out_char;
    logic [LINE_W-1:0] r_out_line;
    logic              r_out_trunc;
    logic              r_out_last;

    // Take-time decode
    logic              take;
    logic [CHAR_W-1:0] c;
    logic              alnum;
    logic              consumed;
    logic              pre_one;
    logic              pre_word;
    logic              kw_hit;
    logic [2:0]        kw_idx;

    // Emission
    logic              slot_free;
    logic              e_valid;
    logic [KIND_W-1:0] e_kind;
    logic [NUM_W-1:0]  e_num;
    logic [CHAR_W-1:0] e_char;
    logic              e_trunc;
    logic              e_last;
    logic              fire;
    logic [LINE_W-1:0] line_up;

    assign take      = (r_state == ST_IDLE) && i_q_valid;
    assign o_q_pop   = take;
    assign c         = i_q_info.ch;
    assign alnum     = i_q_info.is_alpha || i_q_info.is_digit;
    assign slot_free = !r_out_valid || !i_stall;
    assign fire      = e_valid && slot_free;
    assign line_up   = (r_line == LINE_MAX) ? r_line : r_line + 1'b1;

    // Keyword match of the buffered word, from the running per-keyword flags.
    always_comb begin
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int k = 7; k >= 0; k--) begin
            if (r_kw[k] && !r_ovf && r_wcnt == CW'(kw_len(3'(k)))) begin
                kw_hit = 1'b1;
                kw_idx = 3'(k);
            end
        end
    end

    // Decode of the byte at the head of the queue against the current mode.
    always_comb begin
        consumed     = 1'b0;
        pre_one      = 1'b0;
        pre_word     = 1'b0;
        n_pre_kind   = r_pre_kind;
        n_pre_num    = r_pre_num;
        n_pre_char   = r_pre_char;
        n_post_valid = r_post_valid;
        n_post_kind  = r_post_kind;
        n_post_char  = r_post_char;
        n_mode       = r_mode;
        n_wcnt       = r_wcnt;
        n_ovf        = r_ovf;
        n_kw         = r_kw;
        n_acc        = r_acc;
        o_ram_we     = 1'b0;
        o_ram_waddr  = r_wcnt[AW-1:0];
        o_ram_wdata  = c;
        if (take) begin
            n_pre_num    = '0;
            n_pre_char   = '0;
            n_post_valid = 1'b0;
            n_post_kind  = K_EOF;
            n_post_char  = '0;
            // Resolve whatever the previous bytes left pending.
            case (r_mode)
                M_WORD: begin
                    if (alnum) begin
                        consumed = 1'b1;
                        if (r_wcnt < WORD_FULL) begin
                            o_ram_we = 1'b1;
                            n_wcnt   = r_wcnt + 1'b1;
                            for (int k = 0; k < 8; k++) begin
                                n_kw[k] = r_kw[k] && (r_wcnt < CW'(8)) &&
                                          (c == kw_char(3'(k), r_wcnt[2:0]));
                            end
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else if (kw_hit) begin
                        pre_one    = 1'b1;
                        n_pre_kind = K_KEYWORD0 + {2'b00, kw_idx};
                    end else begin
                        pre_word = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (i_q_info.is_digit) begin
                        consumed = 1'b1;
                        n_acc    = (r_acc << 3) + (r_acc << 1) + {28'd0, c[3:0]};
                    end else begin
                        pre_one    = 1'b1;
                        n_pre_kind = K_NUMBER;
                        n_pre_num  = r_acc;
                    end
                end
                M_STRING: begin
                    consumed = 1'b1;
                    pre_one  = 1'b1;
                    if (c == CH_DQUOTE) begin
                        n_pre_kind = K_STRING;
                        n_mode     = M_IDLE;
                    end else if (c == CH_NUL) begin
                        // Unterminated string: error, then end of input.
                        n_pre_kind   = K_ERROR;
                        n_pre_char   = CH_DQUOTE;
                        n_post_valid = 1'b1;
                        n_post_kind  = K_EOF;
                        n_mode       = M_IDLE;
                    end else begin
                        n_pre_kind = K_TEXT;
                        n_pre_char = c;
                    end
                end
                M_EQ1: begin
                    if (c == CH_EQ) begin
                        consumed = 1'b1;
                        n_mode   = M_EQ2;
                    end else begin
                        pre_one    = 1'b1;
                        n_pre_kind = K_PUNCT;
                        n_pre_char = CH_EQ;
                    end
                end
                M_EQ2: begin
                    pre_one = 1'b1;
                    if (c == CH_EQ) begin
                        consumed   = 1'b1;
                        n_pre_kind = K_IS;
                        n_mode     = M_IDLE;
                    end else begin
                        n_pre_kind = K_EQUALS;
                    end
                end
                M_LT: begin
                    pre_one = 1'b1;
                    if (c == CH_EQ) begin
                        consumed   = 1'b1;
                        n_pre_kind = K_LTE;
                        n_mode     = M_IDLE;
                    end else begin
                        n_pre_kind = K_PUNCT;
                        n_pre_char = CH_LT;
                    end
                end
                M_GT: begin
                    pre_one = 1'b1;
                    if (c == CH_EQ) begin
                        consumed   = 1'b1;
                        n_pre_kind = K_GTE;
                        n_mode     = M_IDLE;
                    end else begin
                        n_pre_kind = K_PUNCT;
                        n_pre_char = CH_GT;
                    end
                end
                M_COLON: begin
                    pre_one = 1'b1;
                    if (c == CH_EQ) begin
                        consumed   = 1'b1;
                        n_pre_kind = K_DEFINE;
                        n_mode     = M_IDLE;
                    end else begin
                        n_pre_kind = K_ERROR;
                        n_pre_char = CH_COLON;
                    end
                end
                M_SLASH: begin
                    if (c == CH_SLASH) begin
                        consumed = 1'b1;
                        n_mode   = M_COMMENT;
                    end else begin
                        pre_one    = 1'b1;
                        n_pre_kind = K_PUNCT;
                        n_pre_char = CH_SLASH;
                    end
                end
                M_COMMENT: begin
                    consumed = 1'b1;
                    if (c == CH_LF) begin
                        n_mode = M_IDLE;
                    end else if (c == CH_NUL) begin
                        pre_one    = 1'b1;
                        n_pre_kind = K_EOF;
                        n_mode     = M_IDLE;
                    end
                end
                default: begin
                end
            endcase
            // Scan the byte afresh when the pending mode did not absorb it.
            if (!consumed) begin
                n_mode       = i_q_info.f_mode;
                n_post_valid = i_q_info.f_emit;
                n_post_kind  = i_q_info.f_kind;
                n_post_char  = i_q_info.f_char;
                if (i_q_info.is_alpha) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = '0;
                    n_wcnt      = CW'(1);
                    n_ovf       = 1'b0;
                    for (int k = 0; k < 8; k++) begin
                        n_kw[k] = (c == kw_char(3'(k), 3'd0));
                    end
                end else if (i_q_info.is_digit) begin
                    n_acc = {28'd0, c[3:0]};
                end
            end
        end
    end

    // Result of the current sequencer step.
    always_comb begin
        e_valid = 1'b0;
        e_kind  = r_pre_kind;
        e_num   = '0;
        e_char  = '0;
        e_trunc = 1'b0;
        e_last  = 1'b0;
        case (r_state)
            ST_PRE: begin
                e_valid = 1'b1;
                e_num   = r_pre_num;
                e_char  = r_pre_char;
                e_last  = !r_post_valid;
            end
            ST_FLUSH: begin
                e_valid = 1'b1;
                e_kind  = K_TEXT;
                e_char  = i_ram_rdata;
            end
            ST_ID: begin
                e_valid = 1'b1;
                e_kind  = K_ID;
                e_trunc = r_ovf;
                e_last  = !r_post_valid;
            end
            ST_POST: begin
                e_valid = 1'b1;
                e_kind  = r_post_kind;
                e_char  = r_post_char;
                e_last  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Sequencer, flush index and line counter.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_line  = r_line;
        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    if (pre_one) begin
                        n_state = ST_PRE;
                    end else if (pre_word) begin
                        n_state = ST_FLUSH;
                        n_idx   = '0;
                    end else if (n_post_valid) begin
                        n_state = ST_POST;
                    end
                    // A newline that closes a comment gives no token.
                    if (r_mode == M_COMMENT && c == CH_LF) begin
                        n_line = line_up;
                    end
                end
            end
            ST_PRE, ST_ID: begin
                if (fire) begin
                    n_state = r_post_valid ? ST_POST : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (fire) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx + 1'b1 == r_wcnt) begin
                        n_state = ST_ID;
                    end
                end
            end
            ST_POST: begin
                if (fire) begin
                    n_state = ST_IDLE;
                    // A newline token reports the line that it ends.
                    if (r_post_kind == K_NEWLINE) begin
                        n_line = line_up;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Read address runs one step ahead so that the data matches r_idx.
    assign o_ram_raddr = n_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mode       <= M_IDLE;
            r_wcnt       <= '0;
            r_ovf        <= 1'b0;
            r_kw         <= '0;
            r_acc        <= '0;
            r_line       <= LINE_W'(1);
            r_idx        <= '0;
            r_post_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_wcnt       <= n_wcnt;
            r_ovf        <= n_ovf;
            r_kw         <= n_kw;
            r_acc        <= n_acc;
            r_line       <= n_line;
            r_idx        <= n_idx;
            r_post_valid <= n_post_valid;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Token payload and the output register.
    always_ff @(posedge i_clk) begin
        r_pre_kind  <= n_pre_kind;
        r_pre_num   <= n_pre_num;
        r_pre_char  <= n_pre_char;
        r_post_kind <= n_post_kind;
        r_post_char <= n_post_char;
        if (fire) begin
            r_out_kind  <= e_kind;
            r_out_num   <= e_num;
            r_out_char  <= e_char;
            r_out_line  <= r_line;
            r_out_trunc <= e_trunc;
            r_out_last  <= e_last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_tok_kind       = r_out_kind;
    assign o_num_value      = r_out_num;
    assign o_char_value     = r_out_char;
    assign o_line_no        = r_out_line;
    assign o_word_truncated = r_out_trunc;
    assign o_last           = r_out_last;

    // The line counter starts at one and never wraps to zero.
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0)
        else $error("line counter reached zero");

    // The flush index stays inside the buffered word.
    a_flush_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FLUSH |-> r_idx < r_wcnt)
        else $error("word flush index beyond word length");

    // Sending a newline token advances the line counter unless it saturated.
    a_line_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_state == ST_POST && r_post_kind == K_NEWLINE) |=>
        (r_line == $past(r_line) + 1'b1 || r_line == LINE_MAX))
        else $error("newline token did not advance the line counter");

endmodule

### rtl/source_text_tokenizer.sv
// ============================================================================
// source_text_tokenizer
// Streaming tokenizer for source text: one byte per input beat, tokens out
// one per output beat, with a classifying front end, a two-entry queue and a
// sequencing scanner with a word buffer RAM.
// ============================================================================
//
//  Channel | Ports                                          | Direction
//  --------+------------------------------------------------+----------
//  input   | i_valid, o_stall, i_in_char                    | in
//  output  | o_valid, i_stall, o_tok_kind, o_num_value,     | out
//          | o_char_value, o_line_no, o_word_truncated,     |
//          | o_last                                         |
//
//  The scanner takes a byte from the queue in its idle state, then sends each
//  token that the byte produces; flushing an identifier sends its characters
//  and then the identifier token, one per cycle from the word RAM while the
//  output is not stalled. A byte that only advances the scanner leaves it idle.
//  The front end accepts a new byte while the scanner works, until the queue
//  holds two beats. Reset is synchronous; the word RAM is not cleared, since
//  only entries written for the current word are read back.
//  A stalled output holds its beat; the scanner waits on the output register.
//
module source_text_tokenizer #(
    parameter int MAX_WORD = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_char,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_tok_kind,
    output logic [31:0] o_num_value,
    output logic [7:0]  o_char_value,
    output logic [23:0] o_line_no,
    output logic        o_word_truncated,
    output logic        o_last
);
    import sttok_pkg::*;

    localparam int RAM_AW = $clog2(MAX_WORD);

    logic              q_valid;
    t_char_info        q_info;
    logic              q_pop;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [RAM_AW-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    // Byte classification and queue.
    sttok_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_in_char (i_in_char),
        .o_stall   (o_stall),
        .o_q_valid (q_valid),
        .o_q_info  (q_info),
        .i_q_pop   (q_pop)
    );

    // Word buffer.
    sttok_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WORD)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Scanner and output register.
    sttok_back #(
        .MAX_WORD (MAX_WORD)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_info         (q_info),
        .o_q_pop          (q_pop),
        .o_ram_we         (ram_we),
        .o_ram_waddr      (ram_waddr),
        .o_ram_wdata      (ram_wdata),
        .o_ram_raddr      (ram_raddr),
        .i_ram_rdata      (ram_rdata),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_tok_kind       (o_tok_kind),
        .o_num_value      (o_num_value),
        .o_char_value     (o_char_value),
        .o_line_no        (o_line_no),
        .o_word_truncated (o_word_truncated),
        .o_last           (o_last)
    );

endmodule
